>>> rtl/mhpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam logic [2:0] OP_INSERT   = 3'd0;
  localparam logic [2:0] OP_EXTRACT  = 3'd1;
  localparam logic [2:0] OP_DECREASE = 3'd2;
  localparam logic [2:0] OP_DELETE   = 3'd3;
  localparam logic [2:0] OP_GETMIN   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic [6:0]         CAP_RESET = 7'd64;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] key_value;
    logic [5:0]         entry_index;
  } mhpq_in_t;

  typedef struct packed {
    logic signed [31:0] result_key;
    logic [1:0]         status;
    logic [6:0]         entry_count;
  } mhpq_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP_RD,
    S_UP_CMP,
    S_EXT_RD,
    S_EXT_ROOT,
    S_EXT_LAST,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_GET,
    S_RESP
  } mhpq_state_t;

  // controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       rd_root;
    logic       rd_parent;
    logic       rd_last;
    logic       rd_left;
    logic       rd_right;
    logic       start_ins;
    logic       start_dec;
    logic       start_del;
    logic       up_step;
    logic       dn_step;
    logic       put_cur;
    logic       load_lkey;
    logic       ext_root;
    logic       ext_last;
    logic       get_root;
    logic       set_status;
    logic [1:0] status;
    logic       res_max;
  } mhpq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       empty;
    logic       idx_oor;
    logic       pos_zero;
    logic       l_in;
    logic       r_in;
    logic       up_move;
    logic       dn_move;
    logic       count_one;
  } mhpq_stat_t;

endpackage
`default_nettype wire

>>> rtl/mhpq_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_dpath
// Heap store, sift registers, counters and result registers.
// ----------------------------------------------------------------------------
module mhpq_dpath
  import mhpq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire mhpq_in_t   item,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_value,
  input  wire mhpq_cmd_t  cmd,
  output mhpq_stat_t      stat,
  output mhpq_out_t       result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > 7) ? CW : 7;
  localparam int XW = AW + 2;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;

  logic [2:0]         op;
  logic signed [31:0] key;
  logic [5:0]         idx;
  logic [AW-1:0]      pos;
  logic signed [31:0] cur;
  logic signed [31:0] lkey;
  logic [CW-1:0]      count;
  logic [6:0]         limit;
  logic signed [31:0] res_key;
  logic [1:0]         res_status;

  logic [AW-1:0]      parent;
  logic [XW-1:0]      lw;
  logic [XW-1:0]      rw;
  logic               lt_l;
  logic               take_r;
  logic signed [31:0] best_key;
  logic               re;
  logic [AW-1:0]      ra;
  logic               we;
  logic signed [31:0] wd;

  assign parent   = (pos - 1'b1) >> 1;
  assign lw       = XW'({pos, 1'b1});
  assign rw       = lw + 1'b1;
  assign lt_l     = lkey < cur;
  assign best_key = lt_l ? lkey : cur;
  assign take_r   = stat.r_in && (rdata < best_key);

  always_comb begin
    stat.op        = op;
    stat.full      = (LW'(count) >= LW'(limit)) || (count >= CW'(DEPTH));
    stat.empty     = (count == '0);
    stat.idx_oor   = LW'(idx) >= LW'(count);
    stat.pos_zero  = (pos == '0);
    stat.l_in      = lw < XW'(count);
    stat.r_in      = rw < XW'(count);
    stat.up_move   = rdata > cur;
    stat.dn_move   = take_r || lt_l;
    stat.count_one = (count == CW'(1));
  end

  // read address
  always_comb begin
    re = cmd.rd_root | cmd.rd_parent | cmd.rd_last | cmd.rd_left | cmd.rd_right;
    ra = '0;
    if (cmd.rd_parent) begin
      ra = parent;
    end else if (cmd.rd_last) begin
      ra = AW'(count - 1'b1);
    end else if (cmd.rd_left) begin
      ra = AW'(lw);
    end else if (cmd.rd_right) begin
      ra = AW'(rw);
    end
  end

  // write port, always at the hole position
  always_comb begin
    we = cmd.put_cur | cmd.up_step | cmd.dn_step;
    wd = cur;
    if (cmd.up_step && stat.up_move) begin
      wd = rdata;
    end else if (cmd.dn_step && take_r) begin
      wd = rdata;
    end else if (cmd.dn_step && lt_l) begin
      wd = lkey;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[pos] <= wd;
    end
    if (re) begin
      rdata <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      limit <= CAP_RESET;
    end else begin
      if (cfg_we) begin
        limit <= cfg_value;
      end
      if (cmd.start_ins) begin
        count <= count + 1'b1;
      end else if (cmd.ext_root) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op         <= item.opcode;
      key        <= item.key_value;
      idx        <= item.entry_index;
      res_key    <= '0;
      res_status <= ST_OK;
    end
    if (cmd.set_status) begin
      res_status <= cmd.status;
    end
    if (cmd.res_max) begin
      res_key <= KEY_MAX;
    end
    if (cmd.get_root || (cmd.ext_root && op == OP_EXTRACT)) begin
      res_key <= rdata;
    end
    if (cmd.start_ins) begin
      pos <= AW'(count);
      cur <= key;
    end
    if (cmd.start_dec) begin
      pos <= AW'(idx);
      cur <= key;
    end
    if (cmd.start_del) begin
      pos <= AW'(idx);
      cur <= KEY_MIN;
    end
    if (cmd.up_step && stat.up_move) begin
      pos <= parent;
    end
    if (cmd.ext_last) begin
      pos <= '0;
      cur <= rdata;
    end
    if (cmd.load_lkey) begin
      lkey <= rdata;
    end
    if (cmd.dn_step && take_r) begin
      pos <= AW'(rw);
    end else if (cmd.dn_step && lt_l) begin
      pos <= AW'(lw);
    end
  end

  assign result.result_key  = res_key;
  assign result.status      = res_status;
  assign result.entry_count = 7'(count);

  // one port transfer a cycle on the store, never read and write together
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst) !(we && re))
    else $error("heap store read and written in one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count past depth");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    cmd.start_ins |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the heap");

endmodule
`default_nettype wire

>>> rtl/mhpq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer for one heap operation at a time.
// ----------------------------------------------------------------------------
module mhpq_ctrl
  import mhpq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire mhpq_stat_t stat,
  output mhpq_cmd_t       cmd
);

  mhpq_state_t state;
  mhpq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (stat.op)
          OP_INSERT:   state_next = stat.full ? S_RESP : S_UP_RD;
          OP_EXTRACT:  state_next = stat.empty ? S_RESP : S_EXT_ROOT;
          OP_DECREASE: state_next = stat.idx_oor ? S_RESP : S_UP_RD;
          OP_DELETE:   state_next = stat.idx_oor ? S_RESP : S_UP_RD;
          OP_GETMIN:   state_next = stat.empty ? S_RESP : S_GET;
          default:     state_next = S_RESP;
        endcase
      end
      S_UP_RD: begin
        if (!stat.pos_zero) begin
          state_next = S_UP_CMP;
        end else begin
          state_next = (stat.op == OP_DELETE) ? S_EXT_RD : S_RESP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_move) begin
          state_next = S_UP_RD;
        end else begin
          state_next = (stat.op == OP_DELETE) ? S_EXT_RD : S_RESP;
        end
      end
      S_EXT_RD:   state_next = S_EXT_ROOT;
      S_EXT_ROOT: state_next = stat.count_one ? S_RESP : S_EXT_LAST;
      S_EXT_LAST: state_next = S_DN_L;
      S_DN_L:     state_next = stat.l_in ? S_DN_R : S_RESP;
      S_DN_R:     state_next = S_DN_CMP;
      S_DN_CMP:   state_next = stat.dn_move ? S_DN_L : S_RESP;
      S_GET:      state_next = S_RESP;
      S_RESP: begin
        if (out_ready) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      S_DECODE: begin
        case (stat.op)
          OP_INSERT: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.start_ins = 1'b1;
            end
          end
          OP_EXTRACT, OP_GETMIN: begin
            if (stat.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
              cmd.res_max    = 1'b1;
            end else begin
              cmd.rd_root = 1'b1;
            end
          end
          OP_DECREASE, OP_DELETE: begin
            if (stat.idx_oor) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_RANGE;
            end else if (stat.op == OP_DELETE) begin
              cmd.start_del = 1'b1;
            end else begin
              cmd.start_dec = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_UP_RD: begin
        if (stat.pos_zero) begin
          cmd.put_cur = 1'b1;
        end else begin
          cmd.rd_parent = 1'b1;
        end
      end
      S_UP_CMP:   cmd.up_step = 1'b1;
      S_EXT_RD:   cmd.rd_root = 1'b1;
      S_EXT_ROOT: begin
        cmd.ext_root = 1'b1;
        cmd.rd_last  = !stat.count_one;
      end
      S_EXT_LAST: cmd.ext_last = 1'b1;
      S_DN_L: begin
        if (stat.l_in) begin
          cmd.rd_left = 1'b1;
        end else begin
          cmd.put_cur = 1'b1;
        end
      end
      S_DN_R: begin
        cmd.load_lkey = 1'b1;
        cmd.rd_right  = stat.r_in;
      end
      S_DN_CMP:   cmd.dn_step = 1'b1;
      S_GET:      cmd.get_root = 1'b1;
      S_RESP:     out_valid = 1'b1;
      default: ;
    endcase
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open together");

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && !out_ready) |=> state == S_RESP)
    else $error("result dropped before transfer");

endmodule
`default_nettype wire

>>> rtl/min_heap_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Binary min-heap of signed 32-bit keys with insert, extract, decrease,
// delete and peek operations.
// ----------------------------------------------------------------------------
// One operation is handled at a time and each gives one result transfer.
// Entries live in a single-port-per-direction store of DEPTH words with a
// registered read, so every heap level costs memory round trips: a sift up
// level walks S_UP_RD and S_UP_CMP, a sift down level walks S_DN_L, S_DN_R
// and S_DN_CMP. Rejected and unused ops go from S_DECODE straight to S_RESP,
// peek passes through S_GET, extract on a single entry ends after S_EXT_ROOT,
// and delete runs the sift up walk, then S_EXT_RD, S_EXT_ROOT and S_EXT_LAST,
// then the sift down walk. The store is not cleared after reset; only
// positions below the entry count are ever read. capacity_limit is taken on
// the cfg channel at any time (always ready) and is meant to change only
// while the block is idle.
// ----------------------------------------------------------------------------
module min_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // item channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire mhpq_in_t   in_data,
  // result channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output mhpq_out_t       out_data,
  // capacity_limit write channel
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [6:0] cfg_data
);

  mhpq_cmd_t  cmd;
  mhpq_stat_t stat;

  // register write completes in a single transfer
  assign cfg_ready = 1'b1;

  // sequencer: decodes the op and walks the sift loop
  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // heap store, hole position, moving key and result registers
  mhpq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item      (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (out_data)
  );

endmodule
`default_nettype wire
